// ===== sv/cpcp_pkg.sv =====
// Shared types, widths and helpers for the capsule pair closest point pipeline.
// No dependencies; every other file uses names from here by scope.
package cpcp_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = 17;
   localparam int PROD_W  = 34;
   localparam int DOT_W   = 35;
   localparam int WIDE_W  = 36;
   localparam int LEN_W   = 34;
   localparam int FRAC_W  = 16;
   localparam int PARAM_W = FRAC_W + 1;
   localparam int QUO_W   = PARAM_W;
   localparam int NUM_W   = LEN_W + QUO_W;
   localparam int TN_W    = NUM_W + 2;
   localparam int LIMIT_W = 33;
   localparam int RAD_W   = 17;
   localparam int SEP_W   = 33;
   localparam int MUL_W   = DIFF_W + PARAM_W + 1;
   localparam int SQ_W    = 32;

   localparam int FRONT_STAGES = 4;
   localparam int MID_STAGES   = 2;
   localparam int BACK_STAGES  = 4;
   localparam int DIV_STAGES   = QUO_W;

   localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_W;

   typedef enum logic [3:0] {
      KIND_BOTH = 4'b0001,
      KIND_A_PT = 4'b0010,
      KIND_B_PT = 4'b0100,
      KIND_GEN  = 4'b1000
   } kind_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'b001,
      DST_S    = 3'b010,
      DST_T    = 3'b100
   } dst_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_start_x;
      logic signed [COORD_W-1:0] a_start_y;
      logic signed [COORD_W-1:0] a_end_x;
      logic signed [COORD_W-1:0] a_end_y;
      logic signed [COORD_W-1:0] b_start_x;
      logic signed [COORD_W-1:0] b_start_y;
      logic signed [COORD_W-1:0] b_end_x;
      logic signed [COORD_W-1:0] b_end_y;
      logic        [COORD_W-1:0] radius_a;
      logic        [COORD_W-1:0] radius_b;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] near_a_x;
      logic signed [COORD_W-1:0] near_a_y;
      logic signed [COORD_W-1:0] near_b_x;
      logic signed [COORD_W-1:0] near_b_y;
      logic        [PARAM_W-1:0] param_s;
      logic        [PARAM_W-1:0] param_t;
      logic        [SEP_W-1:0]   separation_sq;
      logic                      overlapping;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] a0x;
      logic signed [COORD_W-1:0] a0y;
      logic signed [COORD_W-1:0] b0x;
      logic signed [COORD_W-1:0] b0y;
      logic signed [DIFF_W-1:0]  d1x;
      logic signed [DIFF_W-1:0]  d1y;
      logic signed [DIFF_W-1:0]  d2x;
      logic signed [DIFF_W-1:0]  d2y;
      logic        [RAD_W-1:0]   rs;
      logic        [LEN_W-1:0]   len_a;
      logic        [LEN_W-1:0]   len_e;
      logic signed [DOT_W-1:0]   dot_b;
      logic signed [DOT_W-1:0]   dot_c;
      logic signed [DOT_W-1:0]   dot_f;
      kind_type                  kind;
      dst_type                   dst;
      logic        [PARAM_W-1:0] s;
      logic        [PARAM_W-1:0] t;
   } ctx_type;

   typedef struct packed {
      ctx_type            ctx;
      logic [NUM_W-1:0]   num;
      logic [LEN_W-1:0]   den;
   } div_req_type;

   typedef struct packed {
      ctx_type            ctx;
      logic [QUO_W-1:0]   quo;
   } div_rsp_type;

   // dividend such that floor(result / den) is the clamped Q1.16 ratio
   function automatic logic [NUM_W-1:0] clamp_num(input logic signed [WIDE_W-1:0] num,
                                                  input logic [LEN_W-1:0] den);
      logic signed [WIDE_W-1:0] den_s;
      den_s = $signed({2'b00, den});
      if (num <= 0) begin
         clamp_num = '0;
      end else if (num >= den_s) begin
         clamp_num = {1'b0, den, {FRAC_W{1'b0}}};
      end else begin
         clamp_num = {1'b0, num[LEN_W-1:0], {FRAC_W{1'b0}}};
      end
   endfunction

endpackage

// ===== sv/cpcp_req_if.sv =====
// Request channel: one capsule pair per beat.
// Depends on cpcp_pkg for field widths.
interface cpcp_req_if;
   logic valid;
   logic ready;
   logic signed [cpcp_pkg::COORD_W-1:0] a_start_x;
   logic signed [cpcp_pkg::COORD_W-1:0] a_start_y;
   logic signed [cpcp_pkg::COORD_W-1:0] a_end_x;
   logic signed [cpcp_pkg::COORD_W-1:0] a_end_y;
   logic signed [cpcp_pkg::COORD_W-1:0] b_start_x;
   logic signed [cpcp_pkg::COORD_W-1:0] b_start_y;
   logic signed [cpcp_pkg::COORD_W-1:0] b_end_x;
   logic signed [cpcp_pkg::COORD_W-1:0] b_end_y;
   logic        [cpcp_pkg::COORD_W-1:0] radius_a;
   logic        [cpcp_pkg::COORD_W-1:0] radius_b;

   modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, radius_a, radius_b,
                  input ready);
   modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                b_start_x, b_start_y, b_end_x, b_end_y, radius_a, radius_b,
                output ready);
endinterface

// ===== sv/cpcp_rsp_if.sv =====
// Response channel: closest points, parameters, separation per beat.
// Depends on cpcp_pkg for field widths.
interface cpcp_rsp_if;
   logic valid;
   logic ready;
   logic signed [cpcp_pkg::COORD_W-1:0] near_a_x;
   logic signed [cpcp_pkg::COORD_W-1:0] near_a_y;
   logic signed [cpcp_pkg::COORD_W-1:0] near_b_x;
   logic signed [cpcp_pkg::COORD_W-1:0] near_b_y;
   logic        [cpcp_pkg::PARAM_W-1:0] param_s;
   logic        [cpcp_pkg::PARAM_W-1:0] param_t;
   logic        [cpcp_pkg::SEP_W-1:0]   separation_sq;
   logic                                overlapping;

   modport source(output valid, near_a_x, near_a_y, near_b_x, near_b_y,
                  param_s, param_t, separation_sq, overlapping, input ready);
   modport sink(input valid, near_a_x, near_a_y, near_b_x, near_b_y,
                param_s, param_t, separation_sq, overlapping, output ready);
endinterface

// ===== sv/cpcp_front.sv =====
// Front end: differences, dot products, case selection, first divider operands.
// Depends on cpcp_pkg.
module cpcp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  cpcp_pkg::req_type               in_data,
   input  logic [cpcp_pkg::LIMIT_W-1:0]    limit,
   output logic                            out_valid,
   input  logic                            out_ready,
   output cpcp_pkg::div_req_type           out_data
);

   typedef struct packed {
      logic signed [cpcp_pkg::COORD_W-1:0] a0x;
      logic signed [cpcp_pkg::COORD_W-1:0] a0y;
      logic signed [cpcp_pkg::COORD_W-1:0] b0x;
      logic signed [cpcp_pkg::COORD_W-1:0] b0y;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d1x;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d1y;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d2x;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d2y;
      logic signed [cpcp_pkg::DIFF_W-1:0]  rx;
      logic signed [cpcp_pkg::DIFF_W-1:0]  ry;
      logic        [cpcp_pkg::RAD_W-1:0]   rs;
   } diff_type;

   typedef struct packed {
      logic signed [cpcp_pkg::COORD_W-1:0] a0x;
      logic signed [cpcp_pkg::COORD_W-1:0] a0y;
      logic signed [cpcp_pkg::COORD_W-1:0] b0x;
      logic signed [cpcp_pkg::COORD_W-1:0] b0y;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d1x;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d1y;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d2x;
      logic signed [cpcp_pkg::DIFF_W-1:0]  d2y;
      logic        [cpcp_pkg::RAD_W-1:0]   rs;
      logic signed [cpcp_pkg::PROD_W-1:0]  aa_x, aa_y, ee_x, ee_y;
      logic signed [cpcp_pkg::PROD_W-1:0]  bb_x, bb_y, cc_x, cc_y, ff_x, ff_y;
      logic signed [cpcp_pkg::PROD_W-1:0]  nn_p, nn_m, dd_p, dd_m;
   } prod_type;

   typedef struct packed {
      cpcp_pkg::ctx_type                   ctx;
      logic signed [cpcp_pkg::DOT_W-1:0]   num;
      logic signed [cpcp_pkg::DOT_W-1:0]   den;
   } dot_type;

   localparam int N = cpcp_pkg::FRONT_STAGES;

   logic [N-1:0] vld_ff;
   logic [N:0]   rdy;
   diff_type     st1_ff, st1_in;
   prod_type     st2_ff, st2_in;
   dot_type      st3_ff, st3_in;
   cpcp_pkg::div_req_type st4_ff, st4_in;

   always_comb begin
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N-1];
   assign out_data  = st4_ff;

   always_comb begin
      st1_in.a0x = in_data.a_start_x;
      st1_in.a0y = in_data.a_start_y;
      st1_in.b0x = in_data.b_start_x;
      st1_in.b0y = in_data.b_start_y;
      st1_in.d1x = in_data.a_end_x - in_data.a_start_x;
      st1_in.d1y = in_data.a_end_y - in_data.a_start_y;
      st1_in.d2x = in_data.b_end_x - in_data.b_start_x;
      st1_in.d2y = in_data.b_end_y - in_data.b_start_y;
      st1_in.rx  = in_data.a_start_x - in_data.b_start_x;
      st1_in.ry  = in_data.a_start_y - in_data.b_start_y;
      st1_in.rs  = {1'b0, in_data.radius_a} + {1'b0, in_data.radius_b};
   end

   always_comb begin
      st2_in.a0x  = st1_ff.a0x;
      st2_in.a0y  = st1_ff.a0y;
      st2_in.b0x  = st1_ff.b0x;
      st2_in.b0y  = st1_ff.b0y;
      st2_in.d1x  = st1_ff.d1x;
      st2_in.d1y  = st1_ff.d1y;
      st2_in.d2x  = st1_ff.d2x;
      st2_in.d2y  = st1_ff.d2y;
      st2_in.rs   = st1_ff.rs;
      st2_in.aa_x = st1_ff.d1x * st1_ff.d1x;
      st2_in.aa_y = st1_ff.d1y * st1_ff.d1y;
      st2_in.ee_x = st1_ff.d2x * st1_ff.d2x;
      st2_in.ee_y = st1_ff.d2y * st1_ff.d2y;
      st2_in.bb_x = st1_ff.d1x * st1_ff.d2x;
      st2_in.bb_y = st1_ff.d1y * st1_ff.d2y;
      st2_in.cc_x = st1_ff.d1x * st1_ff.rx;
      st2_in.cc_y = st1_ff.d1y * st1_ff.ry;
      st2_in.ff_x = st1_ff.d2x * st1_ff.rx;
      st2_in.ff_y = st1_ff.d2y * st1_ff.ry;
      st2_in.nn_p = st1_ff.d2x * st1_ff.ry;
      st2_in.nn_m = st1_ff.d2y * st1_ff.rx;
      st2_in.dd_p = st1_ff.d1x * st1_ff.d2y;
      st2_in.dd_m = st1_ff.d1y * st1_ff.d2x;
   end

   always_comb begin
      st3_in.ctx.a0x   = st2_ff.a0x;
      st3_in.ctx.a0y   = st2_ff.a0y;
      st3_in.ctx.b0x   = st2_ff.b0x;
      st3_in.ctx.b0y   = st2_ff.b0y;
      st3_in.ctx.d1x   = st2_ff.d1x;
      st3_in.ctx.d1y   = st2_ff.d1y;
      st3_in.ctx.d2x   = st2_ff.d2x;
      st3_in.ctx.d2y   = st2_ff.d2y;
      st3_in.ctx.rs    = st2_ff.rs;
      st3_in.ctx.len_a = st2_ff.aa_x + st2_ff.aa_y;
      st3_in.ctx.len_e = st2_ff.ee_x + st2_ff.ee_y;
      st3_in.ctx.dot_b = cpcp_pkg::DOT_W'(st2_ff.bb_x) + cpcp_pkg::DOT_W'(st2_ff.bb_y);
      st3_in.ctx.dot_c = cpcp_pkg::DOT_W'(st2_ff.cc_x) + cpcp_pkg::DOT_W'(st2_ff.cc_y);
      st3_in.ctx.dot_f = cpcp_pkg::DOT_W'(st2_ff.ff_x) + cpcp_pkg::DOT_W'(st2_ff.ff_y);
      st3_in.ctx.kind  = cpcp_pkg::KIND_BOTH;
      st3_in.ctx.dst   = cpcp_pkg::DST_NONE;
      st3_in.ctx.s     = '0;
      st3_in.ctx.t     = '0;
      st3_in.num = cpcp_pkg::DOT_W'(st2_ff.nn_p) - cpcp_pkg::DOT_W'(st2_ff.nn_m);
      st3_in.den = cpcp_pkg::DOT_W'(st2_ff.dd_p) - cpcp_pkg::DOT_W'(st2_ff.dd_m);
   end

   always_comb begin
      logic                                a_pt;
      logic                                e_pt;
      logic signed [cpcp_pkg::WIDE_W-1:0]  num_adj;
      logic signed [cpcp_pkg::WIDE_W-1:0]  den_adj;
      logic signed [cpcp_pkg::WIDE_W-1:0]  neg_c;
      logic signed [cpcp_pkg::WIDE_W-1:0]  f_w;
      a_pt = st3_ff.ctx.len_a <= {1'b0, limit};
      e_pt = st3_ff.ctx.len_e <= {1'b0, limit};
      neg_c = -st3_ff.ctx.dot_c;
      f_w   = st3_ff.ctx.dot_f;
      if (st3_ff.den < 0) begin
         num_adj = -st3_ff.num;
         den_adj = -st3_ff.den;
      end else begin
         num_adj = st3_ff.num;
         den_adj = st3_ff.den;
      end
      st4_in.ctx = st3_ff.ctx;
      st4_in.num = '0;
      st4_in.den = cpcp_pkg::LEN_W'(1);
      if (a_pt && e_pt) begin
         st4_in.ctx.kind = cpcp_pkg::KIND_BOTH;
      end else if (a_pt) begin
         st4_in.ctx.kind = cpcp_pkg::KIND_A_PT;
         st4_in.num = cpcp_pkg::clamp_num(f_w, st3_ff.ctx.len_e);
         st4_in.den = st3_ff.ctx.len_e;
      end else if (e_pt) begin
         st4_in.ctx.kind = cpcp_pkg::KIND_B_PT;
         st4_in.num = cpcp_pkg::clamp_num(neg_c, st3_ff.ctx.len_a);
         st4_in.den = st3_ff.ctx.len_a;
      end else begin
         st4_in.ctx.kind = cpcp_pkg::KIND_GEN;
         if (den_adj != 0) begin
            st4_in.num = cpcp_pkg::clamp_num(num_adj, den_adj[cpcp_pkg::LEN_W-1:0]);
            st4_in.den = den_adj[cpcp_pkg::LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         st1_ff <= st1_in;
      end
      if (rdy[1]) begin
         st2_ff <= st2_in;
      end
      if (rdy[2]) begin
         st3_ff <= st3_in;
      end
      if (rdy[3]) begin
         st4_ff <= st4_in;
      end
   end

endmodule

// ===== sv/cpcp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage; context rides along.
// Depends on cpcp_pkg. Dividend is always below den * 2^QUO_W.
module cpcp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cpcp_pkg::div_req_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cpcp_pkg::div_rsp_type  out_data
);

   typedef struct packed {
      cpcp_pkg::ctx_type              ctx;
      logic [cpcp_pkg::NUM_W-1:0]     rem;
      logic [cpcp_pkg::LEN_W-1:0]     den;
      logic [cpcp_pkg::QUO_W-1:0]     quo;
   } dstage_type;

   localparam int N = cpcp_pkg::DIV_STAGES;

   logic [N-1:0] vld_ff;
   logic [N:0]   rdy;
   dstage_type   st_ff [N];
   dstage_type   st_in [N];

   always_comb begin
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = vld_ff[N-1];
   assign out_data.ctx  = st_ff[N-1].ctx;
   assign out_data.quo  = st_ff[N-1].quo;

   always_comb begin
      dstage_type                 src;
      logic [cpcp_pkg::NUM_W-1:0] dsh;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            src.ctx = in_data.ctx;
            src.rem = in_data.num;
            src.den = in_data.den;
            src.quo = '0;
         end else begin
            src = st_ff[k-1];
         end
         dsh = {{(cpcp_pkg::NUM_W - cpcp_pkg::LEN_W){1'b0}}, src.den} << (N - 1 - k);
         st_in[k] = src;
         if (src.rem >= dsh) begin
            st_in[k].rem = src.rem - dsh;
            st_in[k].quo[N-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

endmodule

// ===== sv/cpcp_mid.sv =====
// Middle: places the first quotient, recomputes t from quantised s, and
// prepares the second divider operands. Depends on cpcp_pkg.
module cpcp_mid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cpcp_pkg::div_rsp_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cpcp_pkg::div_req_type  out_data
);

   typedef struct packed {
      cpcp_pkg::ctx_type                  ctx;
      logic signed [cpcp_pkg::TN_W-1:0]   prod;
      logic signed [cpcp_pkg::WIDE_W-1:0] bmc;
   } mul_type;

   localparam int N = cpcp_pkg::MID_STAGES;

   logic [N-1:0] vld_ff;
   logic [N:0]   rdy;
   mul_type      st1_ff, st1_in;
   cpcp_pkg::div_req_type st2_ff, st2_in;

   always_comb begin
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N-1];
   assign out_data  = st2_ff;

   always_comb begin
      st1_in.ctx = in_data.ctx;
      case (in_data.ctx.kind)
         cpcp_pkg::KIND_A_PT: begin
            st1_in.ctx.s = '0;
            st1_in.ctx.t = in_data.quo;
         end
         cpcp_pkg::KIND_B_PT, cpcp_pkg::KIND_GEN: begin
            st1_in.ctx.s = in_data.quo;
            st1_in.ctx.t = '0;
         end
         default: begin
            st1_in.ctx.s = '0;
            st1_in.ctx.t = '0;
         end
      endcase
      st1_in.prod = in_data.ctx.dot_b * $signed({1'b0, in_data.quo});
      st1_in.bmc  = in_data.ctx.dot_b - in_data.ctx.dot_c;
   end

   always_comb begin
      logic signed [cpcp_pkg::DOT_W+cpcp_pkg::FRAC_W-1:0] f_sh;
      logic signed [cpcp_pkg::TN_W-1:0]                   e_sh;
      logic signed [cpcp_pkg::TN_W-1:0]                   tn;
      logic signed [cpcp_pkg::WIDE_W-1:0]                 neg_c;
      f_sh  = $signed({st1_ff.ctx.dot_f, {cpcp_pkg::FRAC_W{1'b0}}});
      e_sh  = $signed({3'b000, st1_ff.ctx.len_e, {cpcp_pkg::FRAC_W{1'b0}}});
      tn    = st1_ff.prod + f_sh;
      neg_c = -st1_ff.ctx.dot_c;
      st2_in.ctx     = st1_ff.ctx;
      st2_in.ctx.dst = cpcp_pkg::DST_NONE;
      st2_in.num     = '0;
      st2_in.den     = cpcp_pkg::LEN_W'(1);
      if (st1_ff.ctx.kind == cpcp_pkg::KIND_GEN) begin
         if (tn < 0) begin
            st2_in.ctx.t   = '0;
            st2_in.ctx.dst = cpcp_pkg::DST_S;
            st2_in.num     = cpcp_pkg::clamp_num(neg_c, st1_ff.ctx.len_a);
            st2_in.den     = st1_ff.ctx.len_a;
         end else if (tn > e_sh) begin
            st2_in.ctx.t   = cpcp_pkg::PARAM_ONE;
            st2_in.ctx.dst = cpcp_pkg::DST_S;
            st2_in.num     = cpcp_pkg::clamp_num(st1_ff.bmc, st1_ff.ctx.len_a);
            st2_in.den     = st1_ff.ctx.len_a;
         end else begin
            st2_in.ctx.dst = cpcp_pkg::DST_T;
            st2_in.num     = tn[cpcp_pkg::NUM_W-1:0];
            st2_in.den     = st1_ff.ctx.len_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         st1_ff <= st1_in;
      end
      if (rdy[1]) begin
         st2_ff <= st2_in;
      end
   end

endmodule

// ===== sv/cpcp_back.sv =====
// Back end: final parameters, points on both segments, squared separation,
// overlap test; last stage is the response register. Depends on cpcp_pkg.
module cpcp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cpcp_pkg::div_rsp_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cpcp_pkg::rsp_type      out_data
);

   typedef struct packed {
      logic signed [cpcp_pkg::COORD_W-1:0] a0x, a0y, b0x, b0y;
      logic signed [cpcp_pkg::MUL_W-1:0]   max, may, mbx, mby;
      logic        [cpcp_pkg::RAD_W-1:0]   rs;
      logic        [cpcp_pkg::PARAM_W-1:0] s;
      logic        [cpcp_pkg::PARAM_W-1:0] t;
   } mul_type;

   typedef struct packed {
      logic signed [cpcp_pkg::COORD_W-1:0] pax, pay, pbx, pby;
      logic        [cpcp_pkg::RAD_W-1:0]   rs;
      logic        [cpcp_pkg::PARAM_W-1:0] s;
      logic        [cpcp_pkg::PARAM_W-1:0] t;
   } pt_type;

   typedef struct packed {
      logic signed [cpcp_pkg::COORD_W-1:0] pax, pay, pbx, pby;
      logic        [cpcp_pkg::SQ_W-1:0]    dxx, dyy;
      logic        [2*cpcp_pkg::RAD_W-1:0] rs2;
      logic        [cpcp_pkg::PARAM_W-1:0] s;
      logic        [cpcp_pkg::PARAM_W-1:0] t;
   } sq_type;

   localparam int N = cpcp_pkg::BACK_STAGES;

   logic [N-1:0] vld_ff;
   logic [N:0]   rdy;
   mul_type      st1_ff, st1_in;
   pt_type       st2_ff, st2_in;
   sq_type       st3_ff, st3_in;
   cpcp_pkg::rsp_type st4_ff, st4_in;

   function automatic logic signed [cpcp_pkg::COORD_W-1:0] along(
         input logic signed [cpcp_pkg::COORD_W-1:0] start,
         input logic signed [cpcp_pkg::MUL_W-1:0]   m);
      logic signed [cpcp_pkg::MUL_W-1:0] biased;
      logic signed [cpcp_pkg::MUL_W-cpcp_pkg::FRAC_W-1:0] full;
      biased = m + (m[cpcp_pkg::MUL_W-1] ?
                    cpcp_pkg::MUL_W'((1 << cpcp_pkg::FRAC_W) - 1) : '0);
      full = start + $signed(biased[cpcp_pkg::MUL_W-1:cpcp_pkg::FRAC_W]);
      along = full[cpcp_pkg::COORD_W-1:0];
   endfunction

   always_comb begin
      rdy[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[N-1];
   assign out_data  = st4_ff;

   always_comb begin
      logic [cpcp_pkg::PARAM_W-1:0] s_fin;
      logic [cpcp_pkg::PARAM_W-1:0] t_fin;
      s_fin = in_data.ctx.s;
      t_fin = in_data.ctx.t;
      case (in_data.ctx.dst)
         cpcp_pkg::DST_S: s_fin = in_data.quo;
         cpcp_pkg::DST_T: t_fin = in_data.quo;
         default: ;
      endcase
      st1_in.a0x = in_data.ctx.a0x;
      st1_in.a0y = in_data.ctx.a0y;
      st1_in.b0x = in_data.ctx.b0x;
      st1_in.b0y = in_data.ctx.b0y;
      st1_in.max = in_data.ctx.d1x * $signed({1'b0, s_fin});
      st1_in.may = in_data.ctx.d1y * $signed({1'b0, s_fin});
      st1_in.mbx = in_data.ctx.d2x * $signed({1'b0, t_fin});
      st1_in.mby = in_data.ctx.d2y * $signed({1'b0, t_fin});
      st1_in.rs  = in_data.ctx.rs;
      st1_in.s   = s_fin;
      st1_in.t   = t_fin;
   end

   always_comb begin
      st2_in.pax = along(st1_ff.a0x, st1_ff.max);
      st2_in.pay = along(st1_ff.a0y, st1_ff.may);
      st2_in.pbx = along(st1_ff.b0x, st1_ff.mbx);
      st2_in.pby = along(st1_ff.b0y, st1_ff.mby);
      st2_in.rs  = st1_ff.rs;
      st2_in.s   = st1_ff.s;
      st2_in.t   = st1_ff.t;
   end

   always_comb begin
      logic signed [cpcp_pkg::DIFF_W-1:0]   dx;
      logic signed [cpcp_pkg::DIFF_W-1:0]   dy;
      logic signed [2*cpcp_pkg::DIFF_W-1:0] sx;
      logic signed [2*cpcp_pkg::DIFF_W-1:0] sy;
      dx = st2_ff.pax - st2_ff.pbx;
      dy = st2_ff.pay - st2_ff.pby;
      sx = dx * dx;
      sy = dy * dy;
      st3_in.pax = st2_ff.pax;
      st3_in.pay = st2_ff.pay;
      st3_in.pbx = st2_ff.pbx;
      st3_in.pby = st2_ff.pby;
      st3_in.dxx = sx[cpcp_pkg::SQ_W-1:0];
      st3_in.dyy = sy[cpcp_pkg::SQ_W-1:0];
      st3_in.rs2 = st2_ff.rs * st2_ff.rs;
      st3_in.s   = st2_ff.s;
      st3_in.t   = st2_ff.t;
   end

   always_comb begin
      logic [cpcp_pkg::SEP_W-1:0] sep;
      sep = {1'b0, st3_ff.dxx} + {1'b0, st3_ff.dyy};
      st4_in.near_a_x      = st3_ff.pax;
      st4_in.near_a_y      = st3_ff.pay;
      st4_in.near_b_x      = st3_ff.pbx;
      st4_in.near_b_y      = st3_ff.pby;
      st4_in.param_s       = st3_ff.s;
      st4_in.param_t       = st3_ff.t;
      st4_in.separation_sq = sep;
      st4_in.overlapping   = {1'b0, sep} <= st3_ff.rs2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         st1_ff <= st1_in;
      end
      if (rdy[1]) begin
         st2_ff <= st2_in;
      end
      if (rdy[2]) begin
         st3_ff <= st3_in;
      end
      if (rdy[3]) begin
         st4_ff <= st4_in;
      end
   end

endmodule

// ===== sv/capsule_pair_closest_points.sv =====
// Top level: closest points between two 2D capsule segments, fully pipelined.
// Depends on cpcp_pkg, cpcp_req_if, cpcp_rsp_if, cpcp_front, cpcp_div,
// cpcp_mid, cpcp_back.
//
//   channel  dir  handshake               beat
//   req_bus  in   valid/ready             two capsules (endpoints, radii)
//   rsp_bus  out  valid/ready             points, s, t, separation, overlap
//   csr_*    in   write enable, no ready  degeneracy limit, 33 bits
//
// One beat in and one out per cycle while rsp_bus is not stalled; stages are front 4,
// two 17-stage restoring dividers at one quotient bit per stage, middle 2, back 4.
// Reset (synchronous) clears all stage valid bits and the limit to zero.
// Each stage holds while its successor is full and stalled, so bubbles close
// up and a stalled response never blocks intake until the pipe is full.
module capsule_pair_closest_points (
   input  logic                          clock,
   input  logic                          reset,
   cpcp_req_if.sink                      req_bus,
   cpcp_rsp_if.source                    rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [cpcp_pkg::LIMIT_W-1:0]  csr_write_data
);

   logic [cpcp_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   cpcp_pkg::req_type     req_data;
   cpcp_pkg::div_req_type front_data, mid_data;
   cpcp_pkg::div_rsp_type div1_data, div2_data;
   cpcp_pkg::rsp_type     rsp_data;
   logic front_valid, front_ready, div1_valid, div1_ready;
   logic mid_valid, mid_ready, div2_valid, div2_ready;

   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign req_data.a_start_x = req_bus.a_start_x;
   assign req_data.a_start_y = req_bus.a_start_y;
   assign req_data.a_end_x   = req_bus.a_end_x;
   assign req_data.a_end_y   = req_bus.a_end_y;
   assign req_data.b_start_x = req_bus.b_start_x;
   assign req_data.b_start_y = req_bus.b_start_y;
   assign req_data.b_end_x   = req_bus.b_end_x;
   assign req_data.b_end_y   = req_bus.b_end_y;
   assign req_data.radius_a  = req_bus.radius_a;
   assign req_data.radius_b  = req_bus.radius_b;

   cpcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_data),
      .limit     (limit_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   cpcp_div u_div_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (div1_valid),
      .out_ready (div1_ready),
      .out_data  (div1_data)
   );

   cpcp_mid u_mid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div1_valid),
      .in_ready  (div1_ready),
      .in_data   (div1_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   cpcp_div u_div_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (div2_valid),
      .out_ready (div2_ready),
      .out_data  (div2_data)
   );

   cpcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div2_valid),
      .in_ready  (div2_ready),
      .in_data   (div2_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.near_a_x      = rsp_data.near_a_x;
   assign rsp_bus.near_a_y      = rsp_data.near_a_y;
   assign rsp_bus.near_b_x      = rsp_data.near_b_x;
   assign rsp_bus.near_b_y      = rsp_data.near_b_y;
   assign rsp_bus.param_s       = rsp_data.param_s;
   assign rsp_bus.param_t       = rsp_data.param_t;
   assign rsp_bus.separation_sq = rsp_data.separation_sq;
   assign rsp_bus.overlapping   = rsp_data.overlapping;

endmodule
